>>> design/cmh_pkg.sv
package cmh_pkg;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 3;
  localparam int MASK_W    = 64;
  localparam int CNT_W     = 7;
  localparam int N_W       = CNT_W + 1;
  localparam int VDEN_W    = 3 * N_W;
  localparam int OUT_W     = 40;
  localparam int CFG_IDX_W = 1;
  localparam int SIU_W     = 4;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_AND   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PHENO  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRATA = 1'b1;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
  localparam logic [CNT_W-1:0] CT_MAX  = {CNT_W{1'b1}};

  function automatic logic [3:0] pc8(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'b000, v[i]};
    end
    return c;
  endfunction

endpackage

>>> design/cmh_ram.sv
module cmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/cmh_div.sv
module cmh_div #(
  parameter int QW  = 68,
  parameter int DVW = 34
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [QW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [QW-1:0]  quotient
);

  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0]  dvd;
  logic [DVW-1:0] dsr;
  logic [DVW:0]   rem;
  logic [DVW:0]   rem_sh;
  logic           qb;
  logic [CW-1:0]  cnt;
  logic           run;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_sh = {rem[DVW-1:0], dvd[QW-1]};
    qb     = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd <= dividend;
        dsr <= divisor;
        rem <= '0;
        cnt <= CW'(QW);
        run <= 1'b1;
      end else if (run) begin
        rem      <= qb ? (rem_sh - {1'b0, dsr}) : rem_sh;
        dvd      <= dvd << 1;
        quotient <= {quotient[QW-2:0], qb};
        cnt      <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/stratified_cmh_statistic_and_bound.sv
// Stratified Cochran-Mantel-Haenszel statistic with a minimal-p-value bound.
// Load, reset-intersection and AND items are taken in the idle state without
// raising the input stall. An evaluate item walks each used stratum, where used
// is the clamped strata count, and then forms the final squares and quotients.
// QW is the dividend width of the shared bit-serial divider (68 at the default
// parameters). A stratum with n of zero skips its divisions, one with n of one
// or x above n skips its variance division, and a zero variance sum skips the
// final squares and quotients. The divider produces every per-stratum
// expectation and variance and both final quotients, one bit per cycle. Input
// stall stays high while an evaluate is in progress, and also while its result
// waits for a stalled earlier result to leave the output register. A finished
// result waits in the output register while new items are taken.
module stratified_cmh_statistic_and_bound #(
  parameter int MAX_STRATA  = 8,
  parameter int SAMPLE_BITS = 64,
  parameter int FRAC_BITS   = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [cmh_pkg::CMD_W-1:0]       cmd,
  input  logic [cmh_pkg::IDX_W-1:0]       stratum_index,
  input  logic [cmh_pkg::MASK_W-1:0]      sample_mask,
  input  logic [cmh_pkg::CNT_W-1:0]       case_count,
  input  logic [cmh_pkg::CNT_W-1:0]       control_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cmh_pkg::OUT_W-1:0]       chi_statistic,
  output logic [cmh_pkg::OUT_W-1:0]       minimal_bound,
  output logic [cmh_pkg::CNT_W-1:0]       case_total,
  output logic                            degenerate,
  input  logic                            cfg_write,
  input  logic [cmh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cmh_pkg::MASK_W-1:0]      cfg_data
);

  import cmh_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int XW   = $clog2(SB + 1);
  localparam int SAW  = $clog2(MAX_STRATA * SB + 1);
  localparam int DB   = SAW + FRAC_BITS;
  localparam int HW   = (DB + 1) / 2;
  localparam int MIW  = (HW > 16) ? HW : 16;
  localparam int PW   = 2 * MIW;
  localparam int T1W  = 2 * CNT_W;
  localparam int VNW  = T1W + XW + N_W;
  localparam int QA   = 2 * DB;
  localparam int QB   = VNW + FRAC_BITS;
  localparam int QW   = (QA > QB) ? QA : QB;
  localparam int DVW  = (DB > VDEN_W) ? DB : VDEN_W;
  localparam int NB   = (SB + 7) / 8;
  localparam int PCW  = 8 * NB;
  localparam int PCNW = $clog2(NB + 1);
  localparam int JW   = (MAX_STRATA > 1) ? $clog2(MAX_STRATA) : 1;
  localparam int JCW  = $clog2(MAX_STRATA + 1);
  localparam int QX   = (QW > OUT_W) ? QW : OUT_W + 1;
  localparam int SAX  = (SAW > CNT_W) ? SAW : CNT_W + 1;
  localparam int TW   = SB + 2 * CNT_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RD    = 5'd1;
  localparam logic [4:0] S_LOAD  = 5'd2;
  localparam logic [4:0] S_POP   = 5'd3;
  localparam logic [4:0] S_ACC   = 5'd4;
  localparam logic [4:0] S_M1    = 5'd5;
  localparam logic [4:0] S_DIVGO = 5'd6;
  localparam logic [4:0] S_DIVWT = 5'd7;
  localparam logic [4:0] S_M2    = 5'd8;
  localparam logic [4:0] S_M3    = 5'd9;
  localparam logic [4:0] S_M4    = 5'd10;
  localparam logic [4:0] S_M5    = 5'd11;
  localparam logic [4:0] S_M6    = 5'd12;
  localparam logic [4:0] S_NEXT  = 5'd13;
  localparam logic [4:0] S_FIN   = 5'd14;
  localparam logic [4:0] S_SQ0   = 5'd15;
  localparam logic [4:0] S_SQ1   = 5'd16;
  localparam logic [4:0] S_SQ2   = 5'd17;
  localparam logic [4:0] S_SQ3   = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  localparam logic [1:0] K_E   = 2'd0;
  localparam logic [1:0] K_V   = 2'd1;
  localparam logic [1:0] K_CHI = 2'd2;
  localparam logic [1:0] K_BND = 2'd3;

  logic [4:0]       state;
  logic [SB-1:0]    phen;
  logic [SIU_W-1:0] siu;
  logic [SB-1:0]    isect;
  logic [JCW-1:0]   jc;
  logic [JCW-1:0]   used;
  logic [JCW-1:0]   used_c;
  logic [PCW-1:0]   pm;
  logic [PCW-1:0]   pa;
  logic [PCNW-1:0]  pcnt;
  logic [XW-1:0]    x;
  logic [XW-1:0]    a;
  logic [CNT_W-1:0] n1;
  logic [CNT_W-1:0] n2;
  logic [SAW-1:0]   sum_a;
  logic [SAW-1:0]   a_min;
  logic [SAW-1:0]   a_max;
  logic [DB-1:0]    sum_e;
  logic [DB-1:0]    sum_v;
  logic [T1W-1:0]   t1;
  logic [VNW-1:0]   vnum;
  logic [PW-1:0]    prod;
  logic [MIW-1:0]   mul_a;
  logic [MIW-1:0]   mul_b;
  logic [DB-1:0]    dcur;
  logic [DB-1:0]    dbnd;
  logic [2*DB-1:0]  sq;
  logic [1:0]       kind;
  logic [OUT_W-1:0] res_chi;
  logic [OUT_W-1:0] res_bnd;
  logic             res_deg;

  logic             ram_we;
  logic [JW-1:0]    ram_waddr;
  logic [TW-1:0]    ram_wdata;
  logic [TW-1:0]    ram_rdata;
  logic [SB-1:0]    sel_m;

  logic [N_W-1:0]   n;
  logic [N_W-1:0]   nm1;
  logic [N_W-1:0]   x8;
  logic [N_W-1:0]   nx;
  logic [DB-1:0]    a_fx;
  logic [DB-1:0]    mn_fx;
  logic [DB-1:0]    mx_fx;
  logic [DB-1:0]    d_a;
  logic [DB-1:0]    d_mn;
  logic [DB-1:0]    d_mx;
  logic [HW-1:0]    dl;
  logic [DB-HW-1:0] dh;

  logic             div_start;
  logic [QW-1:0]    div_dvd;
  logic [DVW-1:0]   div_dsr;
  logic             div_done;
  logic [QW-1:0]    div_q;
  logic [QX-1:0]    qx;
  logic [OUT_W-1:0] qsat;
  logic [SAX-1:0]   sax;

  assign in_stall = (state != S_IDLE);

  cmh_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_STRATA)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (jc[JW-1:0]),
    .rdata (ram_rdata)
  );

  cmh_div #(
    .QW  (QW),
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    ram_we    = (state == S_IDLE) && in_valid && (cmd == CMD_LOAD) &&
                (32'(stratum_index) < MAX_STRATA);
    ram_waddr = JW'(stratum_index);
    ram_wdata = {sample_mask[SB-1:0], case_count, control_count};
    sel_m     = ~isect & ram_rdata[TW-1:2*CNT_W];

    if (32'(siu) > MAX_STRATA) begin
      used_c = JCW'(MAX_STRATA);
    end else begin
      used_c = JCW'(siu);
    end

    n   = {1'b0, n1} + {1'b0, n2};
    nm1 = n - 1'b1;
    x8  = N_W'(x);
    nx  = n - x8;

    a_fx  = {sum_a, {FRAC_BITS{1'b0}}};
    mn_fx = {a_min, {FRAC_BITS{1'b0}}};
    mx_fx = {a_max, {FRAC_BITS{1'b0}}};
    d_a   = (a_fx >= sum_e) ? (a_fx - sum_e) : (sum_e - a_fx);
    d_mn  = (mn_fx >= sum_e) ? (mn_fx - sum_e) : (sum_e - mn_fx);
    d_mx  = (mx_fx >= sum_e) ? (mx_fx - sum_e) : (sum_e - mx_fx);

    dl = dcur[HW-1:0];
    dh = dcur[DB-1:HW];

    case (state)
      S_M1:    begin mul_a = MIW'(x);     mul_b = MIW'(n1);   end
      S_M2:    begin mul_a = MIW'(n1);    mul_b = MIW'(n2);   end
      S_M3:    begin mul_a = MIW'(x);     mul_b = MIW'(nx);   end
      S_M4:    begin mul_a = MIW'(t1);    mul_b = MIW'(prod); end
      S_M5:    begin mul_a = MIW'(n);     mul_b = MIW'(n);    end
      S_M6:    begin mul_a = MIW'(prod);  mul_b = MIW'(nm1);  end
      S_SQ0:   begin mul_a = MIW'(dl);    mul_b = MIW'(dl);   end
      S_SQ1:   begin mul_a = MIW'(dl);    mul_b = MIW'(dh);   end
      S_SQ2:   begin mul_a = MIW'(dh);    mul_b = MIW'(dh);   end
      default: begin mul_a = '0;          mul_b = '0;         end
    endcase

    div_start = (state == S_DIVGO);
    case (kind)
      K_E: begin
        div_dvd = QW'(prod) << FRAC_BITS;
        div_dsr = DVW'(n);
      end
      K_V: begin
        div_dvd = QW'(vnum) << FRAC_BITS;
        div_dsr = DVW'(prod);
      end
      default: begin
        div_dvd = QW'(sq);
        div_dsr = DVW'(sum_v);
      end
    endcase

    qx   = QX'(div_q);
    qsat = (|(qx >> OUT_W)) ? OUT_MAX : qx[OUT_W-1:0];
    sax  = SAX'(sum_a);
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phen      <= '0;
      siu       <= SIU_W'(1);
      isect     <= '1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PHENO:  phen <= cfg_data[SB-1:0];
          CFG_STRATA: siu  <= cfg_data[SIU_W-1:0];
          default: ;
        endcase
      end

      if ((state == S_OUT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (cmd)
              CMD_RESET: isect <= '1;
              CMD_AND:   isect <= isect & sample_mask[SB-1:0];
              CMD_EVAL: begin
                sum_a <= '0;
                a_min <= '0;
                a_max <= '0;
                sum_e <= '0;
                sum_v <= '0;
                jc    <= '0;
                used  <= used_c;
                state <= (used_c == '0) ? S_FIN : S_RD;
              end
              default: ;
            endcase
          end
        end
        S_RD: state <= S_LOAD;
        S_LOAD: begin
          pm    <= PCW'(sel_m);
          pa    <= PCW'(sel_m & phen);
          n1    <= ram_rdata[2*CNT_W-1:CNT_W];
          n2    <= ram_rdata[CNT_W-1:0];
          x     <= '0;
          a     <= '0;
          pcnt  <= '0;
          state <= S_POP;
        end
        S_POP: begin
          x    <= x + XW'(pc8(pm[7:0]));
          a    <= a + XW'(pc8(pa[7:0]));
          pm   <= pm >> 8;
          pa   <= pa >> 8;
          pcnt <= pcnt + 1'b1;
          if (pcnt == PCNW'(NB - 1)) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          sum_a <= sum_a + SAW'(a);
          a_min <= a_min + ((x8 > {1'b0, n2}) ? SAW'(x8 - {1'b0, n2}) : '0);
          a_max <= a_max + ((x8 < {1'b0, n1}) ? SAW'(x) : SAW'(n1));
          state <= S_M1;
        end
        S_M1: begin
          if (n != '0) begin
            kind  <= K_E;
            state <= S_DIVGO;
          end else begin
            state <= S_M2;
          end
        end
        S_DIVGO: state <= S_DIVWT;
        S_DIVWT: begin
          if (div_done) begin
            case (kind)
              K_E: begin
                sum_e <= sum_e + div_q[DB-1:0];
                state <= S_M2;
              end
              K_V: begin
                sum_v <= sum_v + div_q[DB-1:0];
                state <= S_NEXT;
              end
              K_CHI: begin
                res_chi <= qsat;
                dcur    <= dbnd;
                kind    <= K_BND;
                state   <= S_SQ0;
              end
              default: begin
                res_bnd <= qsat;
                res_deg <= 1'b0;
                state   <= S_OUT;
              end
            endcase
          end
        end
        S_M2: begin
          // A variance term exists only for n above one and x not above n.
          state <= ((n > N_W'(1)) && (x8 <= n)) ? S_M3 : S_NEXT;
        end
        S_M3: begin
          t1    <= prod[T1W-1:0];
          state <= S_M4;
        end
        S_M4: state <= S_M5;
        S_M5: begin
          vnum  <= prod[VNW-1:0];
          state <= S_M6;
        end
        S_M6: begin
          kind  <= K_V;
          state <= S_DIVGO;
        end
        S_NEXT: begin
          jc    <= jc + 1'b1;
          state <= ((jc + 1'b1) == used) ? S_FIN : S_RD;
        end
        S_FIN: begin
          if (sum_v == '0) begin
            res_chi <= '0;
            res_bnd <= '0;
            res_deg <= 1'b1;
            state   <= S_OUT;
          end else begin
            dcur  <= d_a;
            dbnd  <= (d_mn > d_mx) ? d_mn : d_mx;
            kind  <= K_CHI;
            state <= S_SQ0;
          end
        end
        // The square is built from three half-width partial products.
        S_SQ0: state <= S_SQ1;
        S_SQ1: begin
          sq    <= (2*DB)'(prod);
          state <= S_SQ2;
        end
        S_SQ2: begin
          sq    <= sq + ((2*DB)'(prod) << (HW + 1));
          state <= S_SQ3;
        end
        S_SQ3: begin
          sq    <= sq + ((2*DB)'(prod) << (2 * HW));
          state <= S_DIVGO;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            chi_statistic <= res_chi;
            minimal_bound <= res_bnd;
            degenerate    <= res_deg;
            case_total    <= (sax > SAX'(CT_MAX)) ? CT_MAX : sax[CNT_W-1:0];
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
